/* rtl/selective_repeat_sender_window_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the selective-repeat sender window
// Shorthand for clocked implication checks with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_UNIT_MACROS_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_UNIT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define SRSW_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication: when ante holds, cons must hold on the following edge.
`define SRSW_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* rtl/srsw_pkg.sv */
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types, codes and widths of the selective-repeat sender window.
// ----------------------------------------------------------------------------
package srsw_pkg;

    localparam int SEQ_W        = 16;
    localparam int SEQX_W       = SEQ_W + 1;
    localparam int AGE_W        = 16;
    localparam int WSIZE_W      = 5;
    localparam int CMD_W        = 2;
    localparam int KIND_W       = 2;
    localparam int SLOT_O_W     = 4;
    localparam int OUTST_W      = 5;
    localparam int REG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int DIV_CNT_W    = $clog2(SEQ_W);

    localparam int MAX_WINDOW_DEF = 16;

    localparam logic [SEQ_W-1:0]   SEQ_RANGE_RST   = 16'd256;
    localparam logic [SEQ_W-1:0]   SEQ_RANGE_MIN   = 16'd2;
    localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RST = 5'd8;
    localparam logic [AGE_W-1:0]   TIMEOUT_RST     = 16'd1000;
    localparam logic [AGE_W-1:0]   AGE_MAX         = 16'hFFFF;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_SEQ_RANGE   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT     = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_START    = 2'd0,
        CMD_TICK     = 2'd1,
        CMD_ACK      = 2'd2,
        CMD_SRC_DONE = 2'd3
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_NEW    = 2'd0,
        KIND_RETX   = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PREP,
        ST_PASS,
        ST_STATUS
    } t_state;

    // What the head of the ring does to each slot during one rotation.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SEND,
        OP_TICK,
        OP_MARK,
        OP_SHIFT
    } t_pass_op;

    typedef struct packed {
        logic             acked;
        logic [AGE_W-1:0] age;
    } t_slot;

endpackage

/* rtl/srsw_if.sv */
// ----------------------------------------------------------------------------
// srsw interfaces
// Valid/ready channels for requests, results and configuration writes.
// ----------------------------------------------------------------------------
interface srsw_in_if;
    import srsw_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [SEQ_W-1:0]   ack_seq;

    modport source (output valid, output command, output ack_seq, input ready);
    modport sink   (input valid, input command, input ack_seq, output ready);
endinterface

interface srsw_out_if;
    import srsw_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [SEQ_W-1:0]    seq_num;
    logic [SLOT_O_W-1:0] slot;
    logic [OUTST_W-1:0]  outstanding;
    logic                all_done;
    logic                last;

    modport source (
        output valid, output kind, output seq_num, output slot,
        output outstanding, output all_done, output last, input ready
    );
    modport sink (
        input valid, input kind, input seq_num, input slot,
        input outstanding, input all_done, input last, output ready
    );
endinterface

interface srsw_cfg_if;
    import srsw_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [REG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/selective_repeat_sender_window_unit.sv */
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_unit
// Sender side of a selective-repeat sliding window with per-slot ack and age.
// ----------------------------------------------------------------------------
// Requests are taken one at a time. Each request is accepted, passes through
// the bit-serial remainder unit (window base mod sequence range: 16 steps,
// then the remainder is handed back), a preparation state, one rotation of
// the slot ring and the status result. An acknowledgement needs one rotation
// to mark and find the leading acknowledged run and a second one to slide the
// window. Each result also waits for the output register to be free, so a
// stalled sink holds the ring.
// Configuration writes are taken at any time but must only be issued while
// the block is idle.
module selective_repeat_sender_window_unit #(
    parameter int MAX_WINDOW = srsw_pkg::MAX_WINDOW_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srsw_in_if.sink     i_in,
    srsw_out_if.source  o_out,
    srsw_cfg_if.sink    i_cfg
);
    import srsw_pkg::*;

    `include "selective_repeat_sender_window_unit_macros.svh"

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam logic [CNT_W-1:0] T_LAST = CNT_W'(MAX_WINDOW - 1);

    // Control state.
    t_state            r_state, n_state;
    t_pass_op          r_op, n_op;
    logic              r_started, n_started;
    logic              r_src_done, n_src_done;
    logic [SEQ_W-1:0]  r_base, n_base;
    logic [SEQ_W-1:0]  r_seq_range, n_seq_range;
    logic [WSIZE_W-1:0] r_window_size, n_window_size;
    logic [AGE_W-1:0]  r_timeout, n_timeout;
    logic              r_out_valid, n_out_valid;

    // Per-request working registers.
    t_cmd              r_cmd, n_cmd;
    logic [SEQ_W-1:0]  r_ack, n_ack;
    logic [CNT_W-1:0]  r_t, n_t;
    logic [SEQ_W-1:0]  r_seq, n_seq;
    logic              r_lead, n_lead;
    logic [CNT_W-1:0]  r_adv, n_adv;
    logic [SEQ_W-1:0]  r_newseq, n_newseq;
    logic              r_mark_ok, n_mark_ok;
    logic [CNT_W-1:0]  r_mark_off, n_mark_off;
    logic [CNT_W-1:0]  r_outst, n_outst;

    // Output register payload.
    t_kind               r_out_kind;
    logic [SEQ_W-1:0]    r_out_seq;
    logic [SLOT_O_W-1:0] r_out_slot;
    logic [OUTST_W-1:0]  r_out_outst;
    logic                r_out_done;
    logic                r_out_last;

    logic                in_acc, cfg_acc, out_can;
    logic [SEQ_W-1:0]    eff_range, seq_plus, seq_inc;
    logic [CNT_W-1:0]    win, fresh_lo;
    logic                in_win_t;
    logic [AGE_W-1:0]    age_inc;
    logic [SEQX_W-1:0]   ack_n, ack_diff;
    logic                mark_ok;
    logic                mod_done;
    logic [SEQ_W-1:0]    mod_rem;
    logic                shift;
    t_slot               head, tap, ins;
    logic                emit;
    t_kind               emit_kind;
    logic [SEQ_W-1:0]    emit_seq;
    logic [SLOT_O_W-1:0] emit_slot;
    logic [OUTST_W-1:0]  emit_outst;
    logic                emit_done;
    logic                emit_last;

    assign in_acc  = i_in.valid && i_in.ready;
    assign cfg_acc = i_cfg.valid && i_cfg.ready;
    assign out_can = !r_out_valid || o_out.ready;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    srsw_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_acc),
        .i_dividend (r_base),
        .i_divisor  (eff_range),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    srsw_chain #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_shift   (shift),
        .i_tail    (ins),
        .i_tap_idx (r_adv[IDX_W-1:0]),
        .o_head    (head),
        .o_tap     (tap)
    );

    // Effective configuration.
    always_comb begin
        eff_range = (r_seq_range < SEQ_RANGE_MIN) ? SEQ_RANGE_MIN : r_seq_range;
        if (r_window_size == '0) begin
            win = CNT_W'(1);
        end else if (32'(r_window_size) > MAX_WINDOW) begin
            win = CNT_W'(MAX_WINDOW);
        end else begin
            win = CNT_W'(r_window_size);
        end
    end

    assign seq_plus = r_seq + 1'b1;
    assign seq_inc  = (seq_plus == eff_range) ? '0 : seq_plus;
    assign in_win_t = (r_t < win);
    assign age_inc  = (head.age == AGE_MAX) ? head.age : head.age + 1'b1;
    assign fresh_lo = win - r_adv;

    // In-window test for the acknowledged sequence number, with wrap.
    always_comb begin
        if (r_ack < r_base) begin
            ack_n = {1'b0, r_ack} + {1'b0, eff_range};
        end else begin
            ack_n = {1'b0, r_ack};
        end
        ack_diff = ack_n - {1'b0, r_base};
        mark_ok  = (ack_n >= {1'b0, r_base}) && (ack_diff < SEQX_W'(win));
    end

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_started     = r_started;
        n_src_done    = r_src_done;
        n_base        = r_base;
        n_seq_range   = r_seq_range;
        n_window_size = r_window_size;
        n_timeout     = r_timeout;
        n_cmd         = r_cmd;
        n_ack         = r_ack;
        n_t           = r_t;
        n_seq         = r_seq;
        n_lead        = r_lead;
        n_adv         = r_adv;
        n_newseq      = r_newseq;
        n_mark_ok     = r_mark_ok;
        n_mark_off    = r_mark_off;
        n_outst       = r_outst;
        shift         = 1'b0;
        ins           = head;
        emit          = 1'b0;
        emit_kind     = KIND_NEW;
        emit_seq      = r_seq;
        emit_slot     = SLOT_O_W'(r_t);
        emit_outst    = '0;
        emit_done     = 1'b0;
        emit_last     = 1'b0;

        if (cfg_acc) begin
            unique case (i_cfg.index)
                REG_SEQ_RANGE:   n_seq_range   = i_cfg.data;
                REG_WINDOW_SIZE: n_window_size = i_cfg.data[WSIZE_W-1:0];
                REG_TIMEOUT:     n_timeout     = i_cfg.data;
                default: ;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_cmd = t_cmd'(i_in.command);
                    n_ack = i_in.ack_seq;
                    if (t_cmd'(i_in.command) == CMD_SRC_DONE) begin
                        n_src_done = 1'b1;
                    end
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (mod_done) begin
                    n_seq   = mod_rem;
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_mark_ok  = mark_ok;
                n_mark_off = CNT_W'(ack_diff);
                n_t        = '0;
                n_lead     = 1'b1;
                n_adv      = '0;
                n_outst    = '0;
                n_newseq   = r_seq;
                n_op       = OP_HOLD;
                unique case (r_cmd)
                    CMD_START: begin
                        if (!r_started) begin
                            n_started = 1'b1;
                            n_op      = OP_SEND;
                        end
                    end
                    CMD_TICK:     if (r_started) n_op = OP_TICK;
                    CMD_ACK:      if (r_started) n_op = OP_MARK;
                    CMD_SRC_DONE: n_op = OP_HOLD;
                    default:      n_op = OP_HOLD;
                endcase
                n_state = ST_PASS;
            end
            ST_PASS: begin
                if (out_can) begin
                    shift = 1'b1;
                    n_t   = r_t + 1'b1;
                    n_seq = seq_inc;
                    unique case (r_op)
                        OP_HOLD: ins = head;
                        OP_SEND: begin
                            if (in_win_t && !r_src_done) begin
                                ins.acked = 1'b0;
                                ins.age   = '0;
                                emit      = 1'b1;
                                emit_kind = KIND_NEW;
                            end
                        end
                        OP_TICK: begin
                            if (in_win_t && !head.acked) begin
                                ins.age = age_inc;
                                if (age_inc > r_timeout) begin
                                    ins.age   = '0;
                                    emit      = 1'b1;
                                    emit_kind = KIND_RETX;
                                end
                            end
                        end
                        OP_MARK: begin
                            if (in_win_t && r_mark_ok && (r_mark_off == r_t)) begin
                                ins.acked = 1'b1;
                            end
                            // Track the leading acknowledged run and the
                            // sequence number of the slot just past it.
                            if (in_win_t && r_lead) begin
                                if (ins.acked) begin
                                    n_adv    = r_adv + 1'b1;
                                    n_newseq = seq_inc;
                                end else begin
                                    n_lead = 1'b0;
                                end
                            end
                        end
                        OP_SHIFT: begin
                            if (r_t < fresh_lo) begin
                                ins = tap;
                            end else if (in_win_t) begin
                                ins.age   = '0;
                                ins.acked = r_src_done;
                                if (!r_src_done) begin
                                    emit      = 1'b1;
                                    emit_kind = KIND_NEW;
                                end
                            end
                        end
                        default: ins = head;
                    endcase

                    if ((r_op != OP_MARK) && in_win_t && !ins.acked) begin
                        n_outst = r_outst + 1'b1;
                    end

                    if (r_t == T_LAST) begin
                        if (r_op == OP_MARK) begin
                            n_op    = OP_SHIFT;
                            n_t     = '0;
                            n_seq   = n_newseq;
                            n_outst = '0;
                            if (n_adv != '0) begin
                                n_base = n_newseq;
                            end
                        end else begin
                            n_state = ST_STATUS;
                        end
                    end
                end
            end
            ST_STATUS: begin
                if (out_can) begin
                    emit       = 1'b1;
                    emit_kind  = KIND_STATUS;
                    emit_seq   = r_base;
                    emit_slot  = '0;
                    emit_outst = OUTST_W'(r_outst);
                    emit_done  = r_src_done && (r_outst == '0);
                    emit_last  = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        n_out_valid = emit || (r_out_valid && !o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_op          <= OP_HOLD;
            r_started     <= 1'b0;
            r_src_done    <= 1'b0;
            r_base        <= '0;
            r_seq_range   <= SEQ_RANGE_RST;
            r_window_size <= WINDOW_SIZE_RST;
            r_timeout     <= TIMEOUT_RST;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_op          <= n_op;
            r_started     <= n_started;
            r_src_done    <= n_src_done;
            r_base        <= n_base;
            r_seq_range   <= n_seq_range;
            r_window_size <= n_window_size;
            r_timeout     <= n_timeout;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_ack      <= n_ack;
        r_t        <= n_t;
        r_seq      <= n_seq;
        r_lead     <= n_lead;
        r_adv      <= n_adv;
        r_newseq   <= n_newseq;
        r_mark_ok  <= n_mark_ok;
        r_mark_off <= n_mark_off;
        r_outst    <= n_outst;
        if (emit) begin
            r_out_kind  <= emit_kind;
            r_out_seq   <= emit_seq;
            r_out_slot  <= emit_slot;
            r_out_outst <= emit_outst;
            r_out_done  <= emit_done;
            r_out_last  <= emit_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_out_kind;
    assign o_out.seq_num     = r_out_seq;
    assign o_out.slot        = r_out_slot;
    assign o_out.outstanding = r_out_outst;
    assign o_out.all_done    = r_out_done;
    assign o_out.last        = r_out_last;

    // A result is only loaded when the output register can take it.
    `SRSW_IMPLY(a_emit_room, i_clk, i_rst_n, emit, out_can)
    // An accepted request always starts the remainder computation.
    `SRSW_NEXT(a_accept_div, i_clk, i_rst_n, in_acc, r_state == ST_DIV)
    // The leading acknowledged run never runs past the window.
    `SRSW_IMPLY(a_adv_in_win, i_clk, i_rst_n, r_state == ST_PASS, r_adv <= win)
    // Only the status result closes a request.
    `SRSW_IMPLY(a_last_status, i_clk, i_rst_n, r_out_valid && r_out_last,
                r_out_kind == KIND_STATUS)

endmodule

/* rtl/srsw_cell.sv */
// ----------------------------------------------------------------------------
// srsw_cell
// One window slot of the ring: acknowledged flag and age, taken from the
// neighbor whenever the ring moves.
// ----------------------------------------------------------------------------
module srsw_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  srsw_pkg::t_slot i_d,
    output srsw_pkg::t_slot o_q
);
    import srsw_pkg::*;

    t_slot r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.acked <= 1'b1;
            r_q.age   <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

/* rtl/srsw_chain.sv */
// ----------------------------------------------------------------------------
// srsw_chain
// Ring of slot cells. Cell 0 is the head seen by the control logic; the tail
// takes the value written back by the head. One extra tap reads the cell that
// lies a chosen distance ahead of the head.
// ----------------------------------------------------------------------------
module srsw_chain #(
    parameter int MAX_WINDOW = srsw_pkg::MAX_WINDOW_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  srsw_pkg::t_slot i_tail,
    input  logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] i_tap_idx,
    output srsw_pkg::t_slot o_head,
    output srsw_pkg::t_slot o_tap
);
    import srsw_pkg::*;

    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    t_slot q [MAX_WINDOW];

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        t_slot d;
        if (g == MAX_WINDOW - 1) begin : g_tail
            assign d = i_tail;
        end else begin : g_mid
            assign d = q[g+1];
        end
        srsw_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (i_shift),
            .i_d     (d),
            .o_q     (q[g])
        );
    end

    assign o_head = q[0];

    always_comb begin
        o_tap = q[0];
        for (int c = 0; c < MAX_WINDOW; c++) begin
            if (IDX_W'(c) == i_tap_idx) begin
                o_tap = q[c];
            end
        end
    end

endmodule

/* rtl/srsw_mod.sv */
// ----------------------------------------------------------------------------
// srsw_mod
// Bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module srsw_mod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [srsw_pkg::SEQ_W-1:0] i_dividend,
    input  logic [srsw_pkg::SEQ_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [srsw_pkg::SEQ_W-1:0] o_rem
);
    import srsw_pkg::*;

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(SEQ_W - 1);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [SEQ_W-1:0]     r_sh, n_sh;
    logic [SEQ_W-1:0]     r_rem, n_rem;
    logic [SEQX_W-1:0]    trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_sh   = r_sh;
        n_rem  = r_rem;
        trial  = {r_rem, r_sh[SEQ_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_sh   = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            // The partial remainder stays below the divisor, so one subtract
            // per bit is enough.
            if (trial >= {1'b0, i_divisor}) begin
                trial = trial - {1'b0, i_divisor};
            end
            n_rem = trial[SEQ_W-1:0];
            n_sh  = {r_sh[SEQ_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_sh  <= n_sh;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
